FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the alias table builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define AST_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/atb_pkg.sv
// Package with the constants, codes and types of the alias table builder.
`timescale 1ns / 1ps

package atb_pkg;

    // Table size and derived widths.
    localparam int MAX_ENTRIES = 4096;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths of the words on the ports.
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 12;
    localparam int WEIGHT_W = 52;
    localparam int FRAC_W   = 32;
    localparam int PROB_W   = 32;
    localparam int CFG_W    = 13;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;

    // Reset value of the entry count register.
    localparam logic [CFG_W-1:0] ENTRY_COUNT_RESET = CFG_W'(4096);

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // Build sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_PAIR_IDX,
        ST_PAIR_WT,
        ST_PAIR_UPD,
        ST_LARGE_RD,
        ST_LARGE_WR,
        ST_SMALL_RD,
        ST_SMALL_WR
    } atb_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic start;
        logic split_rd;
        logic split_push;
        logic pair_idx_rd;
        logic pair_wt_rd;
        logic pair_upd;
        logic large_rd;
        logic large_wr;
        logic small_rd;
        logic small_wr;
    } atb_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic split_done;
        logic pair_go;
        logic lg_stack_empty;
        logic sm_stack_empty;
    } atb_status_t;

    // One alias table entry.
    typedef struct packed {
        logic             full;
        logic [IDX_W-1:0] alias_idx;
        logic [PROB_W-1:0] prob;
    } atb_entry_t;

endpackage

FILE: rtl/core/atb_ctrl.sv
// Build sequencer of the alias table builder.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                build_go,
    input  atb_pkg::atb_status_t status,
    output atb_pkg::atb_cmd_t    cmd,
    output logic                idle
);
    import atb_pkg::*;

    atb_state_t state_reg;
    atb_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (build_go)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SPLIT_RD;
                end
            end
            ST_SPLIT_RD:
            begin
                if (status.split_done)
                begin
                    state_next = ST_PAIR_IDX;
                end
                else
                begin
                    cmd.split_rd = 1'b1;
                    state_next   = ST_SPLIT_WR;
                end
            end
            ST_SPLIT_WR:
            begin
                cmd.split_push = 1'b1;
                state_next     = ST_SPLIT_RD;
            end
            ST_PAIR_IDX:
            begin
                if (status.pair_go)
                begin
                    cmd.pair_idx_rd = 1'b1;
                    state_next      = ST_PAIR_WT;
                end
                else
                begin
                    state_next = ST_LARGE_RD;
                end
            end
            ST_PAIR_WT:
            begin
                cmd.pair_wt_rd = 1'b1;
                state_next     = ST_PAIR_UPD;
            end
            ST_PAIR_UPD:
            begin
                cmd.pair_upd = 1'b1;
                state_next   = ST_PAIR_IDX;
            end
            ST_LARGE_RD:
            begin
                if (status.lg_stack_empty)
                begin
                    state_next = ST_SMALL_RD;
                end
                else
                begin
                    cmd.large_rd = 1'b1;
                    state_next   = ST_LARGE_WR;
                end
            end
            ST_LARGE_WR:
            begin
                cmd.large_wr = 1'b1;
                state_next   = ST_LARGE_RD;
            end
            ST_SMALL_RD:
            begin
                if (status.sm_stack_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.small_rd = 1'b1;
                    state_next   = ST_SMALL_WR;
                end
            end
            ST_SMALL_WR:
            begin
                cmd.small_wr = 1'b1;
                state_next   = ST_SMALL_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    // The sequencer only leaves idle for a build.
    `AST_NEXT(a_idle_holds, (state_reg == ST_IDLE) && !build_go, state_reg == ST_IDLE,
              "sequencer left idle without a build")
    // At most one datapath command per cycle.
    `AST_IMPLIES(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one command at once")

endmodule

FILE: rtl/core/atb_datapath.sv
// Datapath of the alias table builder: memories, stack pointers, weight update, result stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atb_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  atb_pkg::atb_cmd_t              cmd,
    output atb_pkg::atb_status_t           status,
    input  logic [atb_pkg::CFG_W-1:0]      entry_count,
    input  logic                           s_accept,
    input  logic [atb_pkg::OPCODE_W-1:0]   opcode,
    input  logic [atb_pkg::INDEX_W-1:0]    index,
    input  logic [atb_pkg::WEIGHT_W-1:0]   weight,
    output logic                           in_room,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [atb_pkg::PROB_W-1:0]     probability,
    output logic [atb_pkg::INDEX_W-1:0]    alias_index,
    output logic                           full_entry
);
    import atb_pkg::*;

    // Memories.
    logic [WEIGHT_W-1:0] weight_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]    stack_mem  [MAX_ENTRIES];
    atb_entry_t          table_mem  [MAX_ENTRIES];

    // Registered memory read data.
    logic [WEIGHT_W-1:0] wt_a_reg;
    logic [WEIGHT_W-1:0] wt_b_reg;
    logic [IDX_W-1:0]    stack_a_reg;
    logic [IDX_W-1:0]    stack_b_reg;
    atb_entry_t          table_rd_reg;

    // Stack pointers and build counters.
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] small_top_reg, small_top_next;
    logic [CNT_W-1:0] large_top_reg, large_top_next;
    logic [CNT_W-1:0] active_count;
    logic [CNT_W-1:0] small_m1;
    logic [CNT_W-1:0] large_m1;

    // Result stage.
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_is_read_reg, pend_is_read_next;
    logic              out_valid_reg, out_valid_next;
    logic              pend_advance;
    atb_entry_t        out_entry_reg;

    // Memory port controls.
    logic                wt_we;
    logic [IDX_W-1:0]    wt_waddr;
    logic [WEIGHT_W-1:0] wt_wdata;
    logic                wt_re_a;
    logic [IDX_W-1:0]    wt_raddr_a;
    logic                stack_we;
    logic [IDX_W-1:0]    stack_waddr;
    logic [IDX_W-1:0]    stack_wdata;
    logic                stack_re_a;
    logic                stack_re_b;
    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_waddr;
    atb_entry_t          tbl_wdata;

    // Decoded input operations.
    logic             idx_ok;
    logic             load_go;
    logic             read_go;
    logic [IDX_W-1:0] in_addr;

    // Pairing arithmetic.
    logic [WEIGHT_W:0]   pair_sum;
    logic                sum_ge_one;
    logic [WEIGHT_W-1:0] large_new;
    logic                large_drops;
    logic [PROB_W-1:0]   prob_clamp;
    logic                split_small;
    atb_entry_t          full_mark;

    assign idx_ok  = 32'(index) < 32'(MAX_ENTRIES);
    assign in_addr = IDX_W'(index);
    assign load_go = s_accept && (opcode == OP_LOAD) && idx_ok;
    assign read_go = s_accept && (opcode == OP_READ) && idx_ok;

    // Entry count in use, capped at the table size.
    assign active_count = (32'(entry_count) > 32'(MAX_ENTRIES)) ?
                          CNT_W'(MAX_ENTRIES) : CNT_W'(entry_count);
    assign small_m1 = small_top_reg - CNT_W'(1);
    assign large_m1 = large_top_reg - CNT_W'(1);

    // Status for the sequencer.
    assign status.split_done     = (i_reg == n_reg);
    assign status.pair_go        = (small_top_reg != '0) && (large_top_reg < n_reg);
    assign status.lg_stack_empty = !(large_top_reg < n_reg);
    assign status.sm_stack_empty = (small_top_reg == '0);

    // Weight classification and the pairing update.
    assign split_small = (wt_a_reg[WEIGHT_W-1:FRAC_W] == '0);
    assign pair_sum    = {1'b0, wt_b_reg} + {1'b0, wt_a_reg};
    assign sum_ge_one  = (pair_sum[WEIGHT_W:FRAC_W] != '0);
    assign large_new   = sum_ge_one ?
                         {pair_sum[WEIGHT_W-1:FRAC_W] - (WEIGHT_W-FRAC_W)'(1),
                          pair_sum[FRAC_W-1:0]} : '0;
    assign large_drops = (large_new[WEIGHT_W-1:FRAC_W] == '0);
    assign prob_clamp  = (wt_a_reg[WEIGHT_W-1:FRAC_W] != '0) ? '1 : wt_a_reg[PROB_W-1:0];

    always_comb
    begin
        full_mark.full      = 1'b1;
        full_mark.alias_idx = '0;
        full_mark.prob      = '1;
    end

    // Weight memory port selection.
    assign wt_we      = load_go || cmd.pair_upd;
    assign wt_waddr   = cmd.pair_upd ? stack_b_reg : in_addr;
    assign wt_wdata   = cmd.pair_upd ? large_new : weight;
    assign wt_re_a    = cmd.split_rd || cmd.pair_wt_rd;
    assign wt_raddr_a = cmd.split_rd ? i_reg[IDX_W-1:0] : stack_a_reg;

    // Index stack port selection.
    assign stack_we    = cmd.split_push || (cmd.pair_upd && large_drops);
    assign stack_waddr = cmd.split_push ?
                         (split_small ? small_top_reg[IDX_W-1:0] : large_m1[IDX_W-1:0]) :
                         small_m1[IDX_W-1:0];
    assign stack_wdata = cmd.split_push ? i_reg[IDX_W-1:0] : stack_b_reg;
    assign stack_re_a  = cmd.pair_idx_rd || cmd.small_rd;
    assign stack_re_b  = cmd.pair_idx_rd || cmd.large_rd;

    // Table port selection.
    always_comb
    begin
        tbl_we    = cmd.pair_upd || cmd.large_wr || cmd.small_wr;
        tbl_waddr = cmd.large_wr ? stack_b_reg : stack_a_reg;
        tbl_wdata = full_mark;
        if (cmd.pair_upd)
        begin
            tbl_wdata.full      = 1'b0;
            tbl_wdata.alias_idx = stack_b_reg;
            tbl_wdata.prob      = prob_clamp;
        end
    end

    // Weight memory.
    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            weight_mem[wt_waddr] <= wt_wdata;
        end
        if (wt_re_a)
        begin
            wt_a_reg <= weight_mem[wt_raddr_a];
        end
        if (cmd.pair_wt_rd)
        begin
            wt_b_reg <= weight_mem[stack_b_reg];
        end
    end

    // Index stack memory, small stack from the bottom, large stack from the top.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re_a)
        begin
            stack_a_reg <= stack_mem[small_m1[IDX_W-1:0]];
        end
        if (stack_re_b)
        begin
            stack_b_reg <= stack_mem[large_top_reg[IDX_W-1:0]];
        end
    end

    // Alias table memory.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_mem[tbl_waddr] <= tbl_wdata;
        end
        if (read_go)
        begin
            table_rd_reg <= table_mem[in_addr];
        end
    end

    // Stack pointer and counter updates.
    always_comb
    begin
        n_next         = n_reg;
        i_next         = i_reg;
        small_top_next = small_top_reg;
        large_top_next = large_top_reg;
        if (cmd.start)
        begin
            n_next         = active_count;
            i_next         = '0;
            small_top_next = '0;
            large_top_next = active_count;
        end
        if (cmd.split_push)
        begin
            i_next = i_reg + CNT_W'(1);
            if (split_small)
            begin
                small_top_next = small_top_reg + CNT_W'(1);
            end
            else
            begin
                large_top_next = large_m1;
            end
        end
        if (cmd.pair_upd)
        begin
            if (large_drops)
            begin
                large_top_next = large_top_reg + CNT_W'(1);
            end
            else
            begin
                small_top_next = small_m1;
            end
        end
        if (cmd.large_wr)
        begin
            large_top_next = large_top_reg + CNT_W'(1);
        end
        if (cmd.small_wr)
        begin
            small_top_next = small_m1;
        end
    end

    // Result stage: one pending word behind the output register.
    assign pend_advance = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_room      = !pend_valid_reg || pend_advance;

    always_comb
    begin
        pend_valid_next   = pend_valid_reg;
        pend_is_read_next = pend_is_read_reg;
        out_valid_next    = out_valid_reg;
        if (pend_advance)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s_accept)
        begin
            pend_valid_next   = 1'b1;
            pend_is_read_next = read_go;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg            <= CNT_W'(MAX_ENTRIES);
            i_reg            <= '0;
            small_top_reg    <= '0;
            large_top_reg    <= CNT_W'(MAX_ENTRIES);
            pend_valid_reg   <= 1'b0;
            pend_is_read_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            n_reg            <= n_next;
            i_reg            <= i_next;
            small_top_reg    <= small_top_next;
            large_top_reg    <= large_top_next;
            pend_valid_reg   <= pend_valid_next;
            pend_is_read_reg <= pend_is_read_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (pend_advance)
        begin
            out_entry_reg <= pend_is_read_reg ? table_rd_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign probability = out_entry_reg.prob;
    assign alias_index = INDEX_W'(out_entry_reg.alias_idx);
    assign full_entry  = out_entry_reg.full;

    // The two stacks never overlap.
    `AST_IMPLIES(a_stacks_apart, 1'b1, small_top_reg <= large_top_reg,
                 "small stack ran into large stack")
    // The large stack never reaches past the entries in use.
    `AST_IMPLIES(a_large_bound, 1'b1, large_top_reg <= n_reg,
                 "large stack pointer beyond entry count")
    // A pending word that cannot move blocks new input.
    `AST_IMPLIES(a_no_overrun, pend_valid_reg && out_valid_reg && !out_ready, !in_room,
                 "input accepted with the result stage full")

endmodule

FILE: rtl/core/alias_table_builder_unit.sv
// Top level of the alias table builder: ports, entry count register, sequencer and datapath.
`timescale 1ns / 1ps

// Alias-method table builder.
// Input words (s_tvalid/s_tready/s_tdata) carry an opcode: load a Q20.32
// weight at an index, build the table from the first entry_count weights, or
// read one table entry. Every input word gives exactly one output word on
// m_tvalid/m_tready/m_tdata/m_tuser; load and build give all zeros, a read
// gives the keep probability, the alias index and the full flag.
// The cfg channel writes entry_count (reset 4096); write it only while the
// block is idle.
// Loads and reads take one word per cycle while the result stage has room;
// m_tvalid for a word rises once it has passed the pending stage into the
// output register, so a new word is taken while a result waits.
// A build answers at once, then holds s_tready low while the sequencer walks
// the index stacks: each entry is split in a read and a push state, each
// pairing runs the index, weight and update states, each leftover entry a
// read and a write state; the weight and stack memories have registered reads.
// If the receiver stalls, the output and pending stage fill and s_tready
// drops. Reset clears the control state and the result stage; the memories
// keep no defined contents until written.

module alias_table_builder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [atb_pkg::CFG_W-1:0]         cfg_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [atb_pkg::S_DATA_W-1:0]      s_tdata,  // opcode[1:0], index[13:2], weight[65:14]
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [atb_pkg::M_DATA_W-1:0]      m_tdata,  // probability[31:0], alias_index[43:32]
    output logic                              m_tuser   // full_entry[0]
);
    import atb_pkg::*;

    logic [CFG_W-1:0]    entry_count_reg;
    logic [CFG_W-1:0]    entry_count_next;
    logic                idle;
    logic                in_room;
    logic                s_accept;
    logic                build_go;
    atb_cmd_t            cmd;
    atb_status_t         status;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  index;
    logic [WEIGHT_W-1:0] weight;
    logic [PROB_W-1:0]   probability;
    logic [INDEX_W-1:0]  alias_index;

    // Unpack the input word.
    assign opcode = s_tdata[OPCODE_W-1:0];
    assign index  = s_tdata[OPCODE_W+INDEX_W-1:OPCODE_W];
    assign weight = s_tdata[OPCODE_W+INDEX_W+WEIGHT_W-1:OPCODE_W+INDEX_W];

    // Handshakes.
    assign s_tready  = idle && in_room;
    assign s_accept  = s_tvalid && s_tready;
    assign build_go  = s_accept && (opcode == OP_BUILD);
    assign cfg_ready = idle;

    // Entry count register.
    assign entry_count_next = (cfg_valid && cfg_ready) ? cfg_data : entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RESET;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    atb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .build_go (build_go),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle)
    );

    atb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_count (entry_count_reg),
        .s_accept    (s_accept),
        .opcode      (opcode),
        .index       (index),
        .weight      (weight),
        .in_room     (in_room),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .probability (probability),
        .alias_index (alias_index),
        .full_entry  (m_tuser)
    );

    // Pack the output word.
    assign m_tdata = {(M_DATA_W-PROB_W-INDEX_W)'(0), alias_index, probability};

endmodule

FILE: tb/tb_alias_table_builder_unit.sv
// Self-checking testbench for the alias table builder: directed, stall and random runs.
`timescale 1ns / 1ps

module tb_alias_table_builder_unit;

    import atb_pkg::*;

    // The fourth opcode has no function and must answer with an all-zero word.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Q20.32 constants: 1.0 and 2.0.
    localparam logic [WEIGHT_W:0]   ONE_Q32 = (WEIGHT_W + 1)'(64'h1_0000_0000);
    localparam logic [WEIGHT_W-1:0] TWO_Q32 = WEIGHT_W'(64'h2_0000_0000);

    typedef enum {SET_BALANCED, SET_RANDOM} set_kind_t;

    // One output word as seen on m_tdata and m_tuser.
    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic [IDX_W-1:0]  alias_idx;
        logic              full;
    } table_word_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // opcode[1:0], index[13:2], weight[65:14]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // probability[31:0], alias_index[43:32]
    logic                m_tuser;   // full_entry[0]

    // Shadow copy of the block state used to predict every output word.
    bit [WEIGHT_W-1:0] weight_mem [MAX_ENTRIES];
    bit [IDX_W-1:0]    stack_mem  [MAX_ENTRIES];
    bit [PROB_W-1:0]   prob_mem   [MAX_ENTRIES];
    bit [IDX_W-1:0]    alias_mem  [MAX_ENTRIES];
    bit                full_mem   [MAX_ENTRIES];
    logic [CFG_W-1:0]  count_setting = ENTRY_COUNT_RESET;

    // Entries below these bounds hold written weights and built table entries.
    int          weights_ready  = 0;
    int          table_ready    = 0;

    table_word_t pending_results [$];
    table_word_t got_word;
    table_word_t want_word;
    int          error_count    = 0;
    int          items_sent     = 0;
    int          settle_cycles  = 0;
    int          hold_request   = 0;
    bit          no_idle        = 1'b0;

    alias_table_builder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Effective table size: counts above the table size act as the table size.
    function automatic int active_entries();
        return (count_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_setting);
    endfunction

    function automatic void set_full(int idx);
        prob_mem[idx]  = {PROB_W{1'b1}};
        alias_mem[idx] = '0;
        full_mem[idx]  = 1'b1;
    endfunction

    // Vose construction over the first entries, with the reduced large weights written back.
    function automatic void build_alias_table();
        int        n;
        int        small_cnt;
        int        large_pos;
        int        s_idx;
        int        l_idx;
        bit [WEIGHT_W:0] sum;
        n = active_entries();
        small_cnt = 0;
        large_pos = n;
        // Split: below 1.0 grows up from the bottom, the rest grows down from the top.
        for (int i = 0; i < n; i++)
        begin
            if (weight_mem[i][WEIGHT_W-1:FRAC_W] == '0)
            begin
                stack_mem[small_cnt] = IDX_W'(i);
                small_cnt++;
            end
            else
            begin
                large_pos--;
                stack_mem[large_pos] = IDX_W'(i);
            end
        end
        // Pair the top small entry with the top large entry.
        while (small_cnt > 0 && large_pos < n)
        begin
            small_cnt--;
            s_idx = stack_mem[small_cnt];
            l_idx = stack_mem[large_pos];
            prob_mem[s_idx]  = (weight_mem[s_idx][WEIGHT_W-1:FRAC_W] != '0) ?
                               {PROB_W{1'b1}} : weight_mem[s_idx][FRAC_W-1:0];
            alias_mem[s_idx] = IDX_W'(l_idx);
            full_mem[s_idx]  = 1'b0;
            sum = (WEIGHT_W + 1)'(weight_mem[l_idx]) + (WEIGHT_W + 1)'(weight_mem[s_idx]);
            weight_mem[l_idx] = (sum >= ONE_Q32) ? WEIGHT_W'(sum - ONE_Q32) : '0;
            if (weight_mem[l_idx][WEIGHT_W-1:FRAC_W] == '0)
            begin
                large_pos++;
                stack_mem[small_cnt] = IDX_W'(l_idx);
                small_cnt++;
            end
        end
        // Whatever is left on either stack keeps its own slot.
        while (large_pos < n)
        begin
            set_full(stack_mem[large_pos]);
            large_pos++;
        end
        while (small_cnt > 0)
        begin
            small_cnt--;
            set_full(stack_mem[small_cnt]);
        end
    endfunction

    // Applies one input word to the shadow state and returns the word the block must answer.
    function automatic table_word_t alias_table_step(logic [OPCODE_W-1:0] op,
                                                     logic [INDEX_W-1:0] idx,
                                                     logic [WEIGHT_W-1:0] w);
        table_word_t r;
        r = '0;
        case (op)
            OP_LOAD:
                weight_mem[idx] = w;
            OP_BUILD:
            begin
                build_alias_table();
                if (active_entries() > table_ready)
                    table_ready = active_entries();
            end
            OP_READ:
            begin
                if (full_mem[idx])
                begin
                    r.prob = {PROB_W{1'b1}};
                    r.full = 1'b1;
                end
                else
                begin
                    r.prob      = prob_mem[idx];
                    r.alias_idx = alias_mem[idx];
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        return WEIGHT_W'({$urandom(), $urandom()});
    endfunction

    // Unnormalized weight of random magnitude, up to the full field.
    function automatic logic [WEIGHT_W-1:0] scaled_weight();
        return rand_weight() >> $urandom_range(0, 28);
    endfunction

    // Read index among the built entries, mostly within the current count.
    function automatic logic [INDEX_W-1:0] pick_read_index(int n);
        if ($urandom_range(0, 4) == 0)
            return INDEX_W'($urandom_range(0, table_ready - 1));
        return INDEX_W'($urandom_range(0, n - 1));
    endfunction

    // Offers one input word after a random gap and records its expected answer on acceptance.
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [WEIGHT_W-1:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({w, idx, op});
        do @(posedge clk); while (!s_tready);
        pending_results = {pending_results, alias_table_step(op, idx, w)};
        if (op != OP_UNUSED)
            items_sent++;
        // A build keeps working after its answer; later words are only taken once it is done.
        settle_cycles = (op == OP_BUILD) ? 7 * active_entries() + 16 : 0;
    endtask

    // Stops offering words and waits until every expected word has come back.
    task automatic finish_phase();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the entry count; the block is idle and any build has run to its end.
    task automatic write_entry_count(input logic [CFG_W-1:0] value);
        repeat (settle_cycles) @(posedge clk);
        settle_cycles = 0;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        count_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Loads weights 0..n-1; balanced sets have mean exactly 1.0, with optional stray words mixed in.
    task automatic load_weight_set(input int n, input set_kind_t kind, input bit noisy);
        logic [WEIGHT_W-1:0] vals [$];
        logic [WEIGHT_W-1:0] a;
        logic [WEIGHT_W-1:0] tmp;
        int                  j;
        for (int i = 0; i + 1 < n; i += 2)
        begin
            if (kind == SET_BALANCED)
            begin
                a = (WEIGHT_W'($urandom_range(0, 1)) << FRAC_W) | WEIGHT_W'($urandom());
                vals = {vals, a};
                vals = {vals, TWO_Q32 - a};
            end
            else
            begin
                vals = {vals, scaled_weight()};
                vals = {vals, scaled_weight()};
            end
        end
        if (n % 2 == 1)
            vals = {vals, (kind == SET_BALANCED) ? WEIGHT_W'(ONE_Q32) : scaled_weight()};
        // Shuffle so large and small weights land at random indices.
        for (int i = n - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_word(OP_UNUSED, INDEX_W'($urandom()), rand_weight());
                    1:
                    begin
                        if (table_ready > 0)
                            send_word(OP_READ, INDEX_W'($urandom_range(0, table_ready - 1)),
                                      rand_weight());
                    end
                    default:
                    begin
                        if (n < MAX_ENTRIES)
                            send_word(OP_LOAD, INDEX_W'($urandom_range(n, MAX_ENTRIES - 1)),
                                      scaled_weight());
                    end
                endcase
            end
            send_word(OP_LOAD, INDEX_W'(i), vals[i]);
        end
        if (n > weights_ready)
            weights_ready = n;
    endtask

    // Field limits, every opcode, counts of one and zero, and reads beyond the count.
    task automatic test_directed();
        write_entry_count(CFG_W'(4));
        send_word(OP_LOAD, INDEX_W'(0), '0);
        send_word(OP_LOAD, INDEX_W'(1), '1);
        // Exactly 1.0 goes to the large side, one step below goes to the small side.
        send_word(OP_LOAD, INDEX_W'(2), WEIGHT_W'(ONE_Q32));
        send_word(OP_LOAD, INDEX_W'(3), WEIGHT_W'(ONE_Q32 - 1));
        send_word(OP_LOAD, INDEX_W'(MAX_ENTRIES - 1), '1);
        send_word(OP_UNUSED, '1, '1);
        send_word(OP_BUILD, '0, '0);
        for (int i = 0; i < 4; i++)
            send_word(OP_READ, INDEX_W'(i), '0);
        finish_phase();
        // A single entry is always left over as a full entry.
        write_entry_count(CFG_W'(1));
        send_word(OP_BUILD, '1, '1);
        send_word(OP_READ, INDEX_W'(0), '0);
        send_word(OP_READ, INDEX_W'(1), '0);
        finish_phase();
        // With no entries the build leaves the table untouched.
        write_entry_count('0);
        send_word(OP_BUILD, '0, '0);
        send_word(OP_READ, INDEX_W'(0), '0);
        send_word(OP_READ, INDEX_W'(2), '0);
        finish_phase();
    endtask

    // The receiver holds off for a long stretch while reads keep coming back to back.
    task automatic test_output_stall();
        hold_request = 300;
        no_idle      = 1'b1;
        repeat (40) send_word(OP_READ, INDEX_W'($urandom_range(0, table_ready - 1)),
                              rand_weight());
        no_idle      = 1'b0;
        finish_phase();
    endtask

    // Random sets: mostly balanced weights, some unnormalized, some builds on stale weights.
    task automatic test_random_sets(input int count);
        int target;
        int n;
        int r;
        int reads;
        target = items_sent + count;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            n = (r < 70) ? $urandom_range(1, 16) :
                (r < 95) ? $urandom_range(17, 64) : $urandom_range(65, 300);
            no_idle = ($urandom_range(0, 3) == 0);
            if (count_setting >= 1 && count_setting <= 300 && $urandom_range(0, 5) == 0)
                n = count_setting;
            else
                write_entry_count(CFG_W'(n));
            if (n > weights_ready || $urandom_range(0, 7) != 0)
                load_weight_set(n, ($urandom_range(0, 5) == 0) ? SET_RANDOM : SET_BALANCED, 1'b1);
            send_word(OP_BUILD, INDEX_W'($urandom()), rand_weight());
            reads = $urandom_range(1, n + 2);
            if (reads > 40)
                reads = 40;
            repeat (reads) send_word(OP_READ, pick_read_index(n), rand_weight());
            // A second build works on the weights the first one reduced.
            if ($urandom_range(0, 3) == 0)
            begin
                send_word(OP_BUILD, '0, '0);
                repeat ($urandom_range(1, 6)) send_word(OP_READ, pick_read_index(n), '0);
            end
            finish_phase();
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin : receiver
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic void note_error(string what, table_word_t want, table_word_t got);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] wrong %s: expected prob=%h alias=%h full=%b, got prob=%h alias=%h full=%b",
                     $time, what, want.prob, want.alias_idx, want.full,
                     got.prob, got.alias_idx, got.full);
    endfunction

    // Compares every accepted output word with the oldest expected word.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.prob      = m_tdata[PROB_W-1:0];
            got_word.alias_idx = m_tdata[PROB_W+IDX_W-1:PROB_W];
            got_word.full      = m_tuser;
            if (pending_results.size() == 0)
                note_error("word with nothing pending", '0, got_word);
            else
            begin
                want_word = pending_results.pop_front();
                if (got_word.prob != want_word.prob)
                    note_error("probability", want_word, got_word);
                if (got_word.alias_idx != want_word.alias_idx)
                    note_error("alias index", want_word, got_word);
                if (got_word.full != want_word.full)
                    note_error("full flag", want_word, got_word);
            end
        end
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("alias_table_builder_unit: mismatch");
        $finish;
    end

    // Reset, then the tests in turn.
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_output_stall();
        test_random_sets(490);
        finish_phase();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("alias_table_builder_unit: match");
        else
            $display("alias_table_builder_unit: mismatch");
        $finish;
    end

endmodule
